### hw/rtl/double_sha256_nonce_check_unit_assert.svh
// Assertion helpers for the nonce check unit
`ifndef DOUBLE_SHA256_NONCE_CHECK_UNIT_ASSERT_SVH
`define DOUBLE_SHA256_NONCE_CHECK_UNIT_ASSERT_SVH

// same-cycle implication
`define DSHA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DSHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/dsha_pkg.sv
package dsha_pkg;

    typedef logic [7:0][31:0]  sha_state_t;
    typedef logic [15:0][31:0] sha_msg_t;

    // one stage of the round chain
    typedef struct packed {
        logic       valid;
        sha_state_t state;
        sha_msg_t   w;
        logic [31:0] nonce;
    } cell_t;

    typedef struct packed {
        logic         ok;
        logic [255:0] value;
    } target_t;

    localparam logic [2:0] REG_MIDSTATE_A = 3'd0;
    localparam logic [2:0] REG_MIDSTATE_B = 3'd1;
    localparam logic [2:0] REG_MIDSTATE_C = 3'd2;
    localparam logic [2:0] REG_MIDSTATE_D = 3'd3;
    localparam logic [2:0] REG_HEADER_TAIL = 3'd4;
    localparam logic [2:0] REG_TARGET_BITS = 3'd5;

    localparam logic [31:0] PAD_WORD = 32'h8000_0000;
    localparam logic [31:0] LEN_FIRST = 32'd640;
    localparam logic [31:0] LEN_SECOND = 32'd256;

    localparam sha_state_t INIT_VALUE = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [0:63][31:0] KROUND = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] swap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // compact bits to 256-bit target; ok clear for negative or overflowing targets
    function automatic target_t expand_target(input logic [31:0] bits);
        target_t     r;
        logic [22:0] mant;
        logic [7:0]  b;
        int          pos;
        r.ok = 1'b1;
        r.value = '0;
        mant = bits[22:0];
        if (mant != '0 && bits[23])
            r.ok = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            b = 8'(mant >> (8 * k));
            pos = int'(bits[31:24]) - 3 + k;
            if (b != 8'd0 && pos >= 0)
            begin
                if (pos >= 32)
                    r.ok = 1'b0;
                else
                    r.value[{pos[4:0], 3'b000} +: 8] = b;
            end
        end
        return r;
    endfunction

endpackage

### hw/rtl/double_sha256_nonce_check_unit.sv
// channel | direction | transfer when         | payload
// nonce   | in        | in_valid && !in_stall | nonce
// result  | out       | out_valid && !out_stall | winning_value, hash_word_*
// config  | in        | wr_en                 | wr_index, wr_data
//
// One nonce a cycle enters a chain of 128 SHA-256 round cells while in_stall is low.
// Each nonce passes 64 rounds + feed-forward, twice, then the target compare.
// Only nonces meeting the target produce a transfer on the result side.
// While a result is held by out_stall the whole chain freezes and in_stall rises.
// Reset clears valid flags and configuration; no clearing pass.
module double_sha256_nonce_check_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] nonce,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] winning_value,
    output logic [63:0] hash_word_high,
    output logic [63:0] hash_word_upper_mid,
    output logic [63:0] hash_word_lower_mid,
    output logic [63:0] hash_word_low,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [63:0] wr_data
);
    import dsha_pkg::*;

    logic [63:0] midstate_a_reg, midstate_b_reg, midstate_c_reg, midstate_d_reg;
    logic [63:0] header_tail_reg;
    logic [31:0] target_bits_reg;

    logic         en;
    cell_t        c1_in, c2_in;
    sha_state_t   midstate;
    logic         c1_valid, c2_valid;
    sha_state_t   c1_digest, c2_digest;
    logic [31:0]  c1_nonce, c2_nonce;
    logic [255:0] hash;
    target_t      target_info;
    logic         meets;

    logic         out_valid_reg;
    logic         out_valid_next;
    logic [31:0]  winning_reg;
    logic [255:0] hash_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            midstate_a_reg <= '0;
            midstate_b_reg <= '0;
            midstate_c_reg <= '0;
            midstate_d_reg <= '0;
            header_tail_reg <= '0;
            target_bits_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MIDSTATE_A:  midstate_a_reg <= wr_data;
                REG_MIDSTATE_B:  midstate_b_reg <= wr_data;
                REG_MIDSTATE_C:  midstate_c_reg <= wr_data;
                REG_MIDSTATE_D:  midstate_d_reg <= wr_data;
                REG_HEADER_TAIL: header_tail_reg <= wr_data;
                REG_TARGET_BITS: target_bits_reg <= wr_data[31:0];
                default: ;
            endcase
        end
    end

    assign en = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    assign midstate = {midstate_d_reg[31:0], midstate_d_reg[63:32],
                       midstate_c_reg[31:0], midstate_c_reg[63:32],
                       midstate_b_reg[31:0], midstate_b_reg[63:32],
                       midstate_a_reg[31:0], midstate_a_reg[63:32]};

    always_comb
    begin
        c1_in.valid = in_valid;
        c1_in.state = midstate;
        c1_in.nonce = nonce;
        c1_in.w = '0;
        c1_in.w[0] = header_tail_reg[63:32];
        c1_in.w[1] = header_tail_reg[31:0];
        c1_in.w[2] = swap32(target_bits_reg);
        c1_in.w[3] = swap32(nonce);
        c1_in.w[4] = PAD_WORD;
        c1_in.w[15] = LEN_FIRST;

        c2_in.valid = c1_valid;
        c2_in.state = INIT_VALUE;
        c2_in.nonce = c1_nonce;
        c2_in.w = '0;
        for (int i = 0; i < 8; i++)
            c2_in.w[i] = c1_digest[i];
        c2_in.w[8] = PAD_WORD;
        c2_in.w[15] = LEN_SECOND;
    end

    dsha_compress u_first (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .d      (c1_in),
        .iv     (midstate),
        .valid  (c1_valid),
        .digest (c1_digest),
        .nonce  (c1_nonce)
    );

    dsha_compress u_second (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .d      (c2_in),
        .iv     (INIT_VALUE),
        .valid  (c2_valid),
        .digest (c2_digest),
        .nonce  (c2_nonce)
    );

    // digest read little-endian: word i byte-swapped sits at bits 32i+31..32i
    always_comb
    begin
        for (int i = 0; i < 8; i++)
            hash[i * 32 +: 32] = swap32(c2_digest[i]);
        target_info = expand_target(target_bits_reg);
        meets = target_info.ok && (hash <= target_info.value);
        out_valid_next = en ? (c2_valid && meets) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            winning_reg <= c2_nonce;
            hash_reg <= hash;
        end
    end

    assign out_valid = out_valid_reg;
    assign winning_value = winning_reg;
    assign hash_word_high = hash_reg[255:192];
    assign hash_word_upper_mid = hash_reg[191:128];
    assign hash_word_lower_mid = hash_reg[127:64];
    assign hash_word_low = hash_reg[63:0];

`include "double_sha256_nonce_check_unit_assert.svh"

    `DSHA_ASSERT_NEXT(a_hit_reaches_out, c2_valid && meets && en, out_valid, "hit lost")
    `DSHA_ASSERT_NEXT(a_chain_frozen, out_valid && out_stall, $stable(c2_valid) && $stable(c2_nonce), "chain moved while stalled")
    `DSHA_ASSERT_NOW(a_result_target_ok, out_valid, target_info.ok, "result with invalid target")

endmodule

### hw/rtl/dsha_round_cell.sv
module dsha_round_cell #(
    parameter int ROUND = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  dsha_pkg::cell_t d,
    output dsha_pkg::cell_t q
);
    import dsha_pkg::*;

    logic        valid_reg;
    cell_t       data_reg;
    cell_t       data_next;
    logic [31:0] a, b, c, e, f, g, h, dd;
    logic [31:0] t1, t2, s0, s1;

    always_comb
    begin
        a = d.state[0]; b = d.state[1]; c = d.state[2]; dd = d.state[3];
        e = d.state[4]; f = d.state[5]; g = d.state[6]; h = d.state[7];
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + KROUND[ROUND] + d.w[0];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        s0 = rotr(d.w[1], 7) ^ rotr(d.w[1], 18) ^ (d.w[1] >> 3);
        s1 = rotr(d.w[14], 17) ^ rotr(d.w[14], 19) ^ (d.w[14] >> 10);
        data_next = d;
        data_next.state[0] = t1 + t2;
        data_next.state[1] = a;
        data_next.state[2] = b;
        data_next.state[3] = c;
        data_next.state[4] = dd + t1;
        data_next.state[5] = e;
        data_next.state[6] = f;
        data_next.state[7] = g;
        // schedule window slides by one word each round
        for (int i = 0; i < 15; i++)
            data_next.w[i] = d.w[i + 1];
        data_next.w[15] = d.w[0] + s0 + d.w[9] + s1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= d.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    always_comb
    begin
        q = data_reg;
        q.valid = valid_reg;
    end

endmodule

### hw/rtl/dsha_compress.sv
module dsha_compress (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  dsha_pkg::cell_t      d,
    input  dsha_pkg::sha_state_t iv,
    output logic                 valid,
    output dsha_pkg::sha_state_t digest,
    output logic [31:0]          nonce
);
    import dsha_pkg::*;

    cell_t       link [0:64];
    logic        valid_reg;
    sha_state_t  digest_reg;
    sha_state_t  digest_next;
    logic [31:0] nonce_reg;

    assign link[0] = d;

    for (genvar r = 0; r < 64; r++)
    begin : g_round
        dsha_round_cell #(.ROUND(r)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d     (link[r]),
            .q     (link[r + 1])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            digest_next[i] = link[64].state[i] + iv[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= link[64].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            digest_reg <= digest_next;
            nonce_reg <= link[64].nonce;
        end
    end

    assign valid = valid_reg;
    assign digest = digest_reg;
    assign nonce = nonce_reg;

endmodule
